### hdl/alu16cc_pkg.sv
// ----------------------------------------------------------------------------
// alu16cc_pkg: shared types and constants for the 16-bit ALU
// Opcodes, condition code bit positions and the pipeline item record.
// ----------------------------------------------------------------------------
`default_nettype none

package alu16cc_pkg;

   // operation codes
   typedef enum logic [3:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_CMP   = 4'd2,
      OP_LSR   = 4'd3,
      OP_ASL   = 4'd4,
      OP_INC   = 4'd5,
      OP_DEC   = 4'd6,
      OP_MUL   = 4'd7,
      OP_EMUL  = 4'd8,
      OP_EMULS = 4'd9,
      OP_EDIV  = 4'd10,
      OP_EDIVS = 4'd11,
      OP_IDIV  = 4'd12,
      OP_IDIVS = 4'd13,
      OP_FDIV  = 4'd14,
      OP_DAA   = 4'd15
   } op_type;

   // condition code bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_V = 1;
   localparam int FLAG_Z = 2;
   localparam int FLAG_N = 3;
   localparam int FLAG_H = 5;

   // pipeline depth: one input stage, one setup stage, eight divide stages
   localparam int NUM_STAGES     = 10;
   localparam int DIV_BITS_STAGE = 4;

   // one item as it moves down the pipe
   typedef struct packed {
      op_type             op;
      logic [15:0]        t;
      logic [15:0]        d;
      logic [15:0]        x;
      logic [15:0]        y;
      logic [7:0]         f;
      logic signed [16:0] ma;
      logic signed [16:0] mb;
      logic [31:0]        prod;
      logic [31:0]        num;    // dividend shifting out, quotient shifting in
      logic [15:0]        rem;
      logic [15:0]        dvs;
      logic               negq;
      logic               negr;
      logic               dz;
   } item_type;

endpackage

`default_nettype wire

### hdl/alu16_with_condition_codes_top.sv
// ----------------------------------------------------------------------------
// alu16_with_condition_codes_top: pipelined 16-bit ALU with condition codes
// Add/sub/shift/inc/dec/daa, 8x8 and 16x16 multiplies, and 32/16, 16/16 and
// fractional divides, one operation per transfer.
// ----------------------------------------------------------------------------
//  channel | direction | tdata / tuser
//  req_    | in        | target, operand, reg_d, reg_x, reg_y, flags_in / req_type
//  rsp_    | out       | target_out, d_out, x_out, y_out, flags_out
//
//  One operation enters per cycle unless rsp_ stalls; results pass in order
//  through the stages. Divide: 32 restoring steps, 4 per stage over 8 stages.
//  Reset clears all stage valid bits; payload registers are not reset.
//  Each stage holds while the one after it is full and stalled, so a stall on
//  rsp_ backs up stage by stage and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module alu16_with_condition_codes_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // target[15:0], operand[31:16], reg_d[47:32], reg_x[63:48], reg_y[79:64],
   // flags_in[87:80]
   input  wire logic [87:0] req_tdata,
   // req_type[3:0]
   input  wire logic [3:0]  req_tuser,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // target_out[15:0], d_out[31:16], x_out[47:32], y_out[63:48],
   // flags_out[71:64]
   output      logic [71:0] rsp_tdata
);

   localparam int NS = alu16cc_pkg::NUM_STAGES;

   alu16cc_pkg::item_type pipe_ff [NS];
   alu16cc_pkg::item_type pipe_in [NS];
   logic [NS-1:0]         valid_ff;
   logic [NS:0]           rdy;
   logic                  out_valid_ff;
   logic [71:0]           out_data_ff;
   logic [71:0]           out_data_in;
   alu16cc_pkg::item_type raw;

   // decimal adjust of A; returns {flags, A}
   function automatic logic [15:0] daa_fn(input logic [7:0] f, input logic [7:0] a);
      logic [3:0] ah;
      logic [3:0] al;
      logic [7:0] add;
      logic       nc;
      logic [7:0] r;
      logic [7:0] fo;
      ah  = a[7:4];
      al  = a[3:0];
      add = 8'h00;
      nc  = 1'b0;
      if (!f[alu16cc_pkg::FLAG_C]) begin
         if (!f[alu16cc_pkg::FLAG_H]) begin
            if (ah <= 4'd9 && al <= 4'd9) begin
               add = 8'h00; nc = 1'b0;
            end else if (ah <= 4'd8 && al >= 4'd10) begin
               add = 8'h06; nc = 1'b0;
            end else if (ah >= 4'd10 && al <= 4'd9) begin
               add = 8'h60; nc = 1'b1;
            end else if (ah >= 4'd9 && al >= 4'd10) begin
               add = 8'h66; nc = 1'b1;
            end
         end else if (al <= 4'd3) begin
            if (ah <= 4'd9) begin
               add = 8'h06; nc = 1'b0;
            end else begin
               add = 8'h66; nc = 1'b1;
            end
         end
      end else begin
         if (!f[alu16cc_pkg::FLAG_H]) begin
            if (ah <= 4'd2 && al <= 4'd9) begin
               add = 8'h60; nc = 1'b1;
            end else if (ah <= 4'd2) begin
               add = 8'h66; nc = 1'b1;
            end
         end else if (ah <= 4'd3 && al <= 4'd3) begin
            add = 8'h66; nc = 1'b1;
         end
      end
      r  = a + add;
      fo = f;
      fo[alu16cc_pkg::FLAG_C] = nc;
      fo[alu16cc_pkg::FLAG_Z] = (r == 8'h00);
      fo[alu16cc_pkg::FLAG_N] = r[7];
      return {fo, r};
   endfunction

   // setup stage: short ops finish here, multiply and divide operands prepared
   function automatic alu16cc_pkg::item_type prep2_fn(input alu16cc_pkg::item_type i,
                                                      input logic [15:0] opnd);
      alu16cc_pkg::item_type o;
      logic [15:0] r;
      logic [15:0] a;
      logic [31:0] n;
      logic [15:0] dd;
      logic [15:0] xx;
      logic [15:0] daa_r;
      o     = i;
      a     = i.t;
      n     = {i.y, i.d};
      dd    = i.d[15] ? (16'd0 - i.d) : i.d;
      xx    = i.x[15] ? (16'd0 - i.x) : i.x;
      r     = 16'd0;
      daa_r = 16'd0;
      o.ma  = $signed({1'b0, i.d});
      o.mb  = $signed({1'b0, i.y});
      o.num = n;
      o.dvs = i.x;
      o.rem = 16'd0;
      o.negq = 1'b0;
      o.negr = 1'b0;
      o.dz   = (i.x == 16'd0);
      o.prod = 32'd0;
      unique case (i.op) inside
         alu16cc_pkg::OP_ADD: begin
            r = a + opnd;
            o.f[alu16cc_pkg::FLAG_N] = r[15];
            o.f[alu16cc_pkg::FLAG_Z] = (r == 16'd0);
            o.f[alu16cc_pkg::FLAG_C] = (a[15] & opnd[15]) | (opnd[15] & ~r[15])
                                       | (~r[15] & a[15]);
            o.f[alu16cc_pkg::FLAG_V] = (a[15] & opnd[15] & ~r[15])
                                       | (~a[15] & ~opnd[15] & r[15]);
            o.t = r;
         end
         alu16cc_pkg::OP_SUB, alu16cc_pkg::OP_CMP: begin
            r = a - opnd;
            o.f[alu16cc_pkg::FLAG_N] = r[15];
            o.f[alu16cc_pkg::FLAG_Z] = (r == 16'd0);
            o.f[alu16cc_pkg::FLAG_C] = (~a[15] & opnd[15]) | (opnd[15] & r[15])
                                       | (r[15] & ~a[15]);
            o.f[alu16cc_pkg::FLAG_V] = (a[15] & ~opnd[15] & ~r[15])
                                       | (~a[15] & opnd[15] & r[15]);
            if (i.op == alu16cc_pkg::OP_SUB) begin
               o.t = r;
            end
         end
         alu16cc_pkg::OP_LSR: begin
            r = {1'b0, a[15:1]};
            o.f[alu16cc_pkg::FLAG_N] = 1'b0;
            o.f[alu16cc_pkg::FLAG_C] = a[0];
            o.f[alu16cc_pkg::FLAG_V] = a[0];
            o.f[alu16cc_pkg::FLAG_Z] = (r == 16'd0);
            o.t = r;
         end
         alu16cc_pkg::OP_ASL: begin
            r = {a[14:0], 1'b0};
            o.f[alu16cc_pkg::FLAG_C] = a[15];
            o.f[alu16cc_pkg::FLAG_N] = r[15];
            o.f[alu16cc_pkg::FLAG_Z] = (r == 16'd0);
            o.f[alu16cc_pkg::FLAG_V] = r[15] ^ a[15];
            o.t = r;
         end
         alu16cc_pkg::OP_INC, alu16cc_pkg::OP_DEC: begin
            r = (i.op == alu16cc_pkg::OP_INC) ? (a + 16'd1) : (a - 16'd1);
            o.f[alu16cc_pkg::FLAG_Z] = (r == 16'd0);
            o.t = r;
         end
         alu16cc_pkg::OP_MUL: begin
            o.ma = $signed({9'd0, i.d[15:8]});
            o.mb = $signed({9'd0, i.d[7:0]});
         end
         alu16cc_pkg::OP_EMULS: begin
            o.ma = $signed({i.d[15], i.d});
            o.mb = $signed({i.y[15], i.y});
         end
         alu16cc_pkg::OP_EDIVS: begin
            o.num  = n[31] ? (32'd0 - n) : n;
            o.dvs  = xx;
            o.negq = n[31] ^ i.x[15];
            o.negr = n[31];
         end
         alu16cc_pkg::OP_IDIV: begin
            o.num = {16'd0, i.d};
         end
         alu16cc_pkg::OP_IDIVS: begin
            o.num  = {16'd0, dd};
            o.dvs  = xx;
            o.negq = i.d[15] ^ i.x[15];
            o.negr = i.d[15];
         end
         alu16cc_pkg::OP_FDIV: begin
            o.num = {i.d, 16'd0};
         end
         alu16cc_pkg::OP_DAA: begin
            daa_r = daa_fn(i.f, i.d[15:8]);
            o.f   = daa_r[15:8];
            o.d   = {daa_r[7:0], i.d[7:0]};
         end
         default: begin
         end
      endcase
      return o;
   endfunction

   // four restoring divide steps
   function automatic alu16cc_pkg::item_type div_fn(input alu16cc_pkg::item_type i);
      alu16cc_pkg::item_type o;
      logic [16:0] r2;
      o = i;
      for (int s = 0; s < alu16cc_pkg::DIV_BITS_STAGE; s++) begin
         r2 = {o.rem, o.num[31]};
         if (r2 >= {1'b0, o.dvs}) begin
            r2    = r2 - {1'b0, o.dvs};
            o.num = {o.num[30:0], 1'b1};
         end else begin
            o.num = {o.num[30:0], 1'b0};
         end
         o.rem = r2[15:0];
      end
      return o;
   endfunction

   // result assembly: {flags, y, x, d, target}
   function automatic logic [71:0] fin_fn(input alu16cc_pkg::item_type i);
      logic [15:0] d;
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  f;
      logic [31:0] qs;
      logic [15:0] rs;
      logic        qz;
      d  = i.d;
      x  = i.x;
      y  = i.y;
      f  = i.f;
      qs = i.negq ? (32'd0 - i.num) : i.num;
      rs = i.negr ? (16'd0 - i.rem) : i.rem;
      qz = (i.num == 32'd0);
      unique case (i.op) inside
         alu16cc_pkg::OP_MUL: begin
            d = i.prod[15:0];
            f[alu16cc_pkg::FLAG_C] = i.prod[7];
         end
         alu16cc_pkg::OP_EMUL, alu16cc_pkg::OP_EMULS: begin
            d = i.prod[15:0];
            y = i.prod[31:16];
            f[alu16cc_pkg::FLAG_N] = i.prod[31];
            f[alu16cc_pkg::FLAG_Z] = (i.prod == 32'd0);
            f[alu16cc_pkg::FLAG_C] = i.prod[15];
         end
         alu16cc_pkg::OP_EDIV, alu16cc_pkg::OP_EDIVS, alu16cc_pkg::OP_IDIVS: begin
            f[alu16cc_pkg::FLAG_N] = 1'b0;
            f[alu16cc_pkg::FLAG_Z] = 1'b0;
            f[alu16cc_pkg::FLAG_V] = 1'b0;
            f[alu16cc_pkg::FLAG_C] = 1'b0;
            if (i.dz) begin
               f[alu16cc_pkg::FLAG_C] = 1'b1;
            end else if (i.op == alu16cc_pkg::OP_EDIV) begin
               y = i.num[15:0];
               d = i.rem;
               f[alu16cc_pkg::FLAG_N] = i.num[15];
               f[alu16cc_pkg::FLAG_V] = (i.num[31:16] != 16'd0);
               f[alu16cc_pkg::FLAG_Z] = (i.num[15:0] == 16'd0);
            end else begin
               if (i.op == alu16cc_pkg::OP_EDIVS) begin
                  y = qs[15:0];
               end else begin
                  x = qs[15:0];
               end
               d = rs;
               f[alu16cc_pkg::FLAG_N] = qs[15];
               f[alu16cc_pkg::FLAG_Z] = qz;
               f[alu16cc_pkg::FLAG_V] = i.negq ? (i.num > 32'd32768) : (i.num > 32'd32767);
            end
         end
         alu16cc_pkg::OP_IDIV, alu16cc_pkg::OP_FDIV: begin
            f[alu16cc_pkg::FLAG_Z] = 1'b0;
            f[alu16cc_pkg::FLAG_V] = 1'b0;
            f[alu16cc_pkg::FLAG_C] = 1'b0;
            if (i.dz) begin
               x = 16'hFFFF;
               f[alu16cc_pkg::FLAG_C] = 1'b1;
            end else if (i.op == alu16cc_pkg::OP_FDIV && i.x <= i.d) begin
               x = 16'hFFFF;
               f[alu16cc_pkg::FLAG_V] = 1'b1;
            end else begin
               x = i.num[15:0];
               d = i.rem;
               f[alu16cc_pkg::FLAG_Z] = (i.num[15:0] == 16'd0);
            end
         end
         default: begin
         end
      endcase
      return {f, y, x, d, i.t};
   endfunction

   // input unpack
   always_comb begin
      raw      = '0;
      raw.op   = alu16cc_pkg::op_type'(req_tuser);
      raw.t    = req_tdata[15:0];
      raw.d    = req_tdata[47:32];
      raw.x    = req_tdata[63:48];
      raw.y    = req_tdata[79:64];
      raw.f    = req_tdata[87:80];
      raw.ma   = $signed({1'b0, req_tdata[31:16]});
   end

   // stage next values; operand rides in ma of stage 0
   always_comb begin
      pipe_in[0] = raw;
      pipe_in[1] = prep2_fn(pipe_ff[0], pipe_ff[0].ma[15:0]);
      for (int k = 2; k < NS; k++) begin
         pipe_in[k] = div_fn(pipe_ff[k-1]);
      end
      pipe_in[2].prod = 32'(pipe_ff[1].ma * pipe_ff[1].mb);
      out_data_in = fin_fn(pipe_ff[NS-1]);
   end

   // backpressure chain
   always_comb begin
      rdy[NS] = rsp_tready | ~out_valid_ff;
      for (int k = NS - 1; k >= 0; k--) begin
         rdy[k] = ~valid_ff[k] | rdy[k+1];
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rdy[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NS; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
         if (rdy[NS]) begin
            out_valid_ff <= valid_ff[NS-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NS; k++) begin
         if (rdy[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
      if (rdy[NS]) begin
         out_data_ff <= out_data_in;
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

`default_nettype wire

### dv/alu16_with_condition_codes_top_test.sv
// ----------------------------------------------------------------------------
// alu16_with_condition_codes_top_test: stream-level check of the 16-bit ALU
// Directed corner operations, then random ones, go in on req_ with random
// gaps. An in-bench predictor computes each result, and every rsp_ transfer is
// compared field by field, in order, against the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module alu16_with_condition_codes_top_test;

   // one operation as sent on req_
   typedef struct {
      alu16cc_pkg::op_type op;
      logic [15:0] t;
      logic [15:0] b;
      logic [15:0] d;
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  f;
   } alu_op_type;

   // one result as seen on rsp_
   typedef struct {
      logic [15:0] t;
      logic [15:0] d;
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  f;
   } alu_res_type;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [3:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [71:0] rsp_tdata;

   alu_op_type  pending_ops[$];
   alu_res_type predicted_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          stim_done = 0;

   alu16_with_condition_codes_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decimal adjust of accumulator A
   function automatic void decimal_adjust(ref logic [7:0] a, ref logic [7:0] f);
      logic [3:0] hi;
      logic [3:0] lo;
      logic [7:0] add;
      logic       nc;
      hi  = a[7:4];
      lo  = a[3:0];
      add = 8'h00;
      nc  = 1'b0;
      if (!f[alu16cc_pkg::FLAG_C]) begin
         if (!f[alu16cc_pkg::FLAG_H]) begin
            if (hi <= 4'd9 && lo <= 4'd9) begin
               add = 8'h00;
            end else if (hi <= 4'd8 && lo >= 4'd10) begin
               add = 8'h06;
            end else if (hi >= 4'd10 && lo <= 4'd9) begin
               add = 8'h60; nc = 1'b1;
            end else if (hi >= 4'd9 && lo >= 4'd10) begin
               add = 8'h66; nc = 1'b1;
            end
         end else if (lo <= 4'd3) begin
            if (hi <= 4'd9) begin
               add = 8'h06;
            end else begin
               add = 8'h66; nc = 1'b1;
            end
         end
      end else begin
         if (!f[alu16cc_pkg::FLAG_H]) begin
            if (hi <= 4'd2 && lo <= 4'd9) begin
               add = 8'h60; nc = 1'b1;
            end else if (hi <= 4'd2) begin
               add = 8'h66; nc = 1'b1;
            end
         end else if (hi <= 4'd3 && lo <= 4'd3) begin
            add = 8'h66; nc = 1'b1;
         end
      end
      a = a + add;
      f[alu16cc_pkg::FLAG_C] = nc;
      f[alu16cc_pkg::FLAG_Z] = (a == 8'h00);
      f[alu16cc_pkg::FLAG_N] = a[7];
   endfunction

   // predicted result of one ALU operation
   function automatic alu_res_type alu_predict(alu_op_type o);
      alu_res_type r;
      logic [15:0] w;
      logic [7:0]  a;
      logic [7:0]  f;
      logic [31:0] p;
      logic [31:0] num;
      logic [31:0] uq;
      logic signed [63:0] sn;
      logic signed [63:0] sd;
      logic signed [63:0] sq;
      logic signed [63:0] sr;
      r.t = o.t; r.d = o.d; r.x = o.x; r.y = o.y;
      f = o.f;
      case (o.op) inside
         alu16cc_pkg::OP_ADD: begin
            w = o.t + o.b;
            f[alu16cc_pkg::FLAG_N] = w[15];
            f[alu16cc_pkg::FLAG_Z] = (w == 16'h0);
            f[alu16cc_pkg::FLAG_C] = (o.t[15] & o.b[15]) | (o.b[15] & ~w[15])
                                     | (~w[15] & o.t[15]);
            f[alu16cc_pkg::FLAG_V] = (o.t[15] & o.b[15] & ~w[15])
                                     | (~o.t[15] & ~o.b[15] & w[15]);
            r.t = w;
         end
         alu16cc_pkg::OP_SUB, alu16cc_pkg::OP_CMP: begin
            w = o.t - o.b;
            f[alu16cc_pkg::FLAG_N] = w[15];
            f[alu16cc_pkg::FLAG_Z] = (w == 16'h0);
            f[alu16cc_pkg::FLAG_C] = (~o.t[15] & o.b[15]) | (o.b[15] & w[15])
                                     | (w[15] & ~o.t[15]);
            f[alu16cc_pkg::FLAG_V] = (o.t[15] & ~o.b[15] & ~w[15])
                                     | (~o.t[15] & o.b[15] & w[15]);
            if (o.op == alu16cc_pkg::OP_SUB) r.t = w;
         end
         alu16cc_pkg::OP_LSR: begin
            w = o.t >> 1;
            f[alu16cc_pkg::FLAG_C] = o.t[0];
            f[alu16cc_pkg::FLAG_V] = o.t[0];
            f[alu16cc_pkg::FLAG_N] = 1'b0;
            f[alu16cc_pkg::FLAG_Z] = (w == 16'h0);
            r.t = w;
         end
         alu16cc_pkg::OP_ASL: begin
            w = o.t << 1;
            f[alu16cc_pkg::FLAG_C] = o.t[15];
            f[alu16cc_pkg::FLAG_N] = w[15];
            f[alu16cc_pkg::FLAG_Z] = (w == 16'h0);
            f[alu16cc_pkg::FLAG_V] = w[15] ^ o.t[15];
            r.t = w;
         end
         alu16cc_pkg::OP_INC, alu16cc_pkg::OP_DEC: begin
            w = (o.op == alu16cc_pkg::OP_INC) ? o.t + 16'd1 : o.t - 16'd1;
            f[alu16cc_pkg::FLAG_Z] = (w == 16'h0);
            r.t = w;
         end
         alu16cc_pkg::OP_MUL: begin
            w = {8'h0, o.d[15:8]} * {8'h0, o.d[7:0]};
            f[alu16cc_pkg::FLAG_C] = w[7];
            r.d = w;
         end
         alu16cc_pkg::OP_EMUL, alu16cc_pkg::OP_EMULS: begin
            if (o.op == alu16cc_pkg::OP_EMUL) begin
               p = {16'h0, o.d} * {16'h0, o.y};
            end else begin
               p = $signed({{16{o.d[15]}}, o.d}) * $signed({{16{o.y[15]}}, o.y});
            end
            f[alu16cc_pkg::FLAG_N] = p[31];
            f[alu16cc_pkg::FLAG_Z] = (p == 32'h0);
            f[alu16cc_pkg::FLAG_C] = p[15];
            r.d = p[15:0];
            r.y = p[31:16];
         end
         alu16cc_pkg::OP_EDIV, alu16cc_pkg::OP_EDIVS: begin
            f[alu16cc_pkg::FLAG_N] = 1'b0; f[alu16cc_pkg::FLAG_Z] = 1'b0;
            f[alu16cc_pkg::FLAG_V] = 1'b0; f[alu16cc_pkg::FLAG_C] = 1'b0;
            if (o.x == 16'h0) begin
               f[alu16cc_pkg::FLAG_C] = 1'b1;
            end else begin
               num = {o.y, o.d};
               if (o.op == alu16cc_pkg::OP_EDIV) begin
                  uq  = num / {16'h0, o.x};
                  r.d = 16'(num % {16'h0, o.x});
                  f[alu16cc_pkg::FLAG_N] = uq[15];
                  f[alu16cc_pkg::FLAG_V] = (uq > 32'hFFFF);
                  f[alu16cc_pkg::FLAG_Z] = (uq[15:0] == 16'h0);
                  r.y = uq[15:0];
               end else begin
                  sn = {{32{num[31]}}, num};
                  sd = {{48{o.x[15]}}, o.x};
                  sq = sn / sd;
                  sr = sn % sd;
                  f[alu16cc_pkg::FLAG_N] = sq[15];
                  f[alu16cc_pkg::FLAG_Z] = (sq == 64'sd0);
                  f[alu16cc_pkg::FLAG_V] = (sq > 64'sd32767 || sq < -64'sd32768);
                  r.y = sq[15:0];
                  r.d = sr[15:0];
               end
            end
         end
         alu16cc_pkg::OP_IDIV: begin
            f[alu16cc_pkg::FLAG_Z] = 1'b0; f[alu16cc_pkg::FLAG_V] = 1'b0;
            f[alu16cc_pkg::FLAG_C] = 1'b0;
            if (o.x == 16'h0) begin
               r.x = 16'hFFFF;
               f[alu16cc_pkg::FLAG_C] = 1'b1;
            end else begin
               r.x = o.d / o.x;
               r.d = o.d % o.x;
               f[alu16cc_pkg::FLAG_Z] = (r.x == 16'h0);
            end
         end
         alu16cc_pkg::OP_IDIVS: begin
            f[alu16cc_pkg::FLAG_N] = 1'b0; f[alu16cc_pkg::FLAG_Z] = 1'b0;
            f[alu16cc_pkg::FLAG_V] = 1'b0; f[alu16cc_pkg::FLAG_C] = 1'b0;
            if (o.x == 16'h0) begin
               f[alu16cc_pkg::FLAG_C] = 1'b1;
            end else begin
               sn = {{48{o.d[15]}}, o.d};
               sd = {{48{o.x[15]}}, o.x};
               sq = sn / sd;
               sr = sn % sd;
               f[alu16cc_pkg::FLAG_V] = (sq > 64'sd32767 || sq < -64'sd32768);
               f[alu16cc_pkg::FLAG_Z] = (sq == 64'sd0);
               f[alu16cc_pkg::FLAG_N] = sq[15];
               r.x = sq[15:0];
               r.d = sr[15:0];
            end
         end
         alu16cc_pkg::OP_FDIV: begin
            f[alu16cc_pkg::FLAG_Z] = 1'b0; f[alu16cc_pkg::FLAG_V] = 1'b0;
            f[alu16cc_pkg::FLAG_C] = 1'b0;
            if (o.x == 16'h0) begin
               r.x = 16'hFFFF;
               f[alu16cc_pkg::FLAG_C] = 1'b1;
            end else if (o.x <= o.d) begin
               r.x = 16'hFFFF;
               f[alu16cc_pkg::FLAG_V] = 1'b1;
            end else begin
               num = {o.d, 16'h0};
               r.x = 16'(num / {16'h0, o.x});
               r.d = 16'(num % {16'h0, o.x});
               f[alu16cc_pkg::FLAG_Z] = (r.x == 16'h0);
            end
         end
         default: begin
            a = o.d[15:8];
            decimal_adjust(a, f);
            r.d = {a, o.d[7:0]};
         end
      endcase
      r.f = f;
      return r;
   endfunction

   function automatic alu_op_type make_op(alu16cc_pkg::op_type op, logic [15:0] t,
                                          logic [15:0] b, logic [15:0] d,
                                          logic [15:0] x, logic [15:0] y,
                                          logic [7:0] f);
      alu_op_type o;
      o.op = op; o.t = t; o.b = b; o.d = d; o.x = x; o.y = y; o.f = f;
      return o;
   endfunction

   // random 16-bit value biased toward edges
   function automatic logic [15:0] edgy16();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return 16'(($urandom_range(0, 1)) ? 1 : 2);
         default: return 16'($urandom);
      endcase
   endfunction

   // stimulus
   initial begin
      alu_op_type o;
      int         k;
      // directed corners
      pending_ops.push_back(make_op(alu16cc_pkg::OP_ADD, 16'hFFFF, 16'h0001,
                                    16'h0, 16'h0, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_ADD, 16'h7FFF, 16'h0001,
                                    16'h0, 16'h0, 16'h0, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_SUB, 16'h8000, 16'h0001,
                                    16'h0, 16'h0, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_SUB, 16'h0000, 16'hFFFF,
                                    16'h0, 16'h0, 16'h0, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_CMP, 16'h1234, 16'h1234,
                                    16'h0, 16'h0, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_LSR, 16'h0001, 16'h0,
                                    16'h0, 16'h0, 16'h0, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_ASL, 16'h8000, 16'h0,
                                    16'h0, 16'h0, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_INC, 16'hFFFF, 16'h0,
                                    16'h0, 16'h0, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_DEC, 16'h0001, 16'h0,
                                    16'h0, 16'h0, 16'h0, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_MUL, 16'h0, 16'h0,
                                    16'hFFFF, 16'h0, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_EMUL, 16'h0, 16'h0,
                                    16'hFFFF, 16'h0, 16'hFFFF, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_EMULS, 16'h0, 16'h0,
                                    16'h8000, 16'h0, 16'h8000, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_EDIV, 16'h0, 16'h0,
                                    16'h1234, 16'h0000, 16'h5678, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_EDIV, 16'h0, 16'h0,
                                    16'hFFFF, 16'h0001, 16'hFFFF, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_EDIVS, 16'h0, 16'h0,
                                    16'h0000, 16'h0000, 16'h8000, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_EDIVS, 16'h0, 16'h0,
                                    16'h0000, 16'hFFFF, 16'h8000, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_IDIV, 16'h0, 16'h0,
                                    16'hFFFF, 16'h0000, 16'h0, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_IDIV, 16'h0, 16'h0,
                                    16'hFFFF, 16'h0007, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_IDIVS, 16'h0, 16'h0,
                                    16'h8000, 16'h0000, 16'h0, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_IDIVS, 16'h0, 16'h0,
                                    16'h8000, 16'hFFFF, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_FDIV, 16'h0, 16'h0,
                                    16'h1000, 16'h0000, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_FDIV, 16'h0, 16'h0,
                                    16'h2000, 16'h2000, 16'h0, 8'hFF));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_FDIV, 16'h0, 16'h0,
                                    16'h0001, 16'hFFFF, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_DAA, 16'h0, 16'h0,
                                    16'h9A00, 16'h0, 16'h0, 8'h00));
      pending_ops.push_back(make_op(alu16cc_pkg::OP_DAA, 16'h0, 16'h0,
                                    16'h2255, 16'h0, 16'h0, 8'h21));
      // random operations
      for (k = 0; k < 800; k++) begin
         o.op = alu16cc_pkg::op_type'(4'($urandom_range(0, 15)));
         o.t  = edgy16();
         o.b  = edgy16();
         o.d  = edgy16();
         o.x  = ($urandom_range(0, 9) == 0) ? 16'h0 : edgy16();
         o.y  = edgy16();
         o.f  = 8'($urandom);
         // keep fractional divides mostly in range
         if (o.op == alu16cc_pkg::OP_FDIV && $urandom_range(0, 3) != 0 && o.x <= o.d)
            o.d = o.x >> $urandom_range(1, 8);
         // signed divides: some small quotients
         if (o.op == alu16cc_pkg::OP_EDIVS && $urandom_range(0, 1) == 1)
            o.y = {16{o.d[15]}};
         pending_ops.push_back(o);
      end
      stim_done = 1'b1;
   end

   // reset
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // idle pattern: no idle cycles in a stretch in the middle of the run
   function automatic logic pick_idle();
      if (cycle_count > 300 && cycle_count < 600) return 1'b0;
      return ($urandom_range(0, 99) < 11);
   endfunction

   // driver: changes on the falling edge
   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
   end

   logic req_fired;
   always @(negedge clock) begin
      alu_op_type o;
      if (!reset) begin
         if (req_fired || !req_tvalid) begin
            if (pending_ops.size() > 0 && !pick_idle()) begin
               o = pending_ops.pop_front();
               req_tdata  <= {o.f, o.y, o.x, o.d, o.b, o.t};
               req_tuser  <= o.op;
               req_tvalid <= 1'b1;
               predicted_results.push_back(alu_predict(o));
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !pick_idle();
      end
   end

   // monitor: samples on the rising edge
   always @(posedge clock) begin
      alu_res_type exp_r;
      alu_res_type got;
      cycle_count <= cycle_count + 1;
      req_fired <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.t = rsp_tdata[15:0];
         got.d = rsp_tdata[31:16];
         got.x = rsp_tdata[47:32];
         got.y = rsp_tdata[63:48];
         got.f = rsp_tdata[71:64];
         if (predicted_results.size() == 0) begin
            $error("unexpected result transfer %h", rsp_tdata);
            error_count++;
         end else begin
            exp_r = predicted_results.pop_front();
            if (got.t !== exp_r.t) begin
               $error("target_out expected %h got %h", exp_r.t, got.t); error_count++;
            end
            if (got.d !== exp_r.d) begin
               $error("d_out expected %h got %h", exp_r.d, got.d); error_count++;
            end
            if (got.x !== exp_r.x) begin
               $error("x_out expected %h got %h", exp_r.x, got.x); error_count++;
            end
            if (got.y !== exp_r.y) begin
               $error("y_out expected %h got %h", exp_r.y, got.y); error_count++;
            end
            if (got.f !== exp_r.f) begin
               $error("flags_out expected %h got %h", exp_r.f, got.f); error_count++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait ((stim_done && pending_ops.size() == 0) || cycle_count >= CYCLE_LIMIT);
      while ((predicted_results.size() != 0 || req_tvalid) && cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (cycle_count >= CYCLE_LIMIT || predicted_results.size() != 0
          || pending_ops.size() != 0) begin
         $display("alu16_with_condition_codes_top_test: errors");
      end else if (error_count == 0) begin
         $display("alu16_with_condition_codes_top_test: clean");
      end else begin
         $display("alu16_with_condition_codes_top_test: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
